[hdl/cdc_pkg.sv]
// Shared types, constants and the gear table of the content-defined chunker.
`timescale 1ns / 1ps
package cdc_pkg;

    localparam int LENGTH_BITS_DEF   = 24;
    localparam int OFFSET_BITS_DEF   = 48;
    localparam int MAX_MASK_BITS_DEF = 21;

    // The mask builder covers mask sizes up to 21 bits, the default MAX_MASK_BITS.
    localparam int MASK_BITS_LIMIT = 21;
    localparam int MASK_K_W        = 5;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 24;
    localparam int BYTE_W      = 8;
    localparam int HASH_W      = 64;
    localparam int OFFSET_W    = 48;
    localparam int LENGTH_W    = 24;
    localparam int CAUSE_W     = 3;
    localparam int GEAR_DEPTH  = 256;

    localparam logic [CFG_INDEX_W-1:0] CFG_MIN    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TARGET = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX    = 2'd2;

    localparam logic [CFG_DATA_W-1:0] RESET_MIN    = 24'd16384;
    localparam logic [CFG_DATA_W-1:0] RESET_TARGET = 24'd65536;
    localparam logic [CFG_DATA_W-1:0] RESET_MAX    = 24'd262144;

    localparam logic [HASH_W-1:0] MIX_GAMMA = 64'h9E3779B97F4A7C15;
    localparam logic [HASH_W-1:0] MIX_MUL1  = 64'hBF58476D1CE4E5B9;
    localparam logic [HASH_W-1:0] MIX_MUL2  = 64'h94D049BB133111EB;

    typedef enum logic [CAUSE_W-1:0] {
        CAUSE_NONE   = 3'd0,
        CAUSE_STRICT = 3'd1,
        CAUSE_LOOSE  = 3'd2,
        CAUSE_MAX    = 3'd3,
        CAUSE_EOD    = 3'd4
    } cut_cause_t;

    typedef logic [GEAR_DEPTH-1:0][HASH_W-1:0] gear_rom_t;

    // SplitMix64 sequence, evaluated at elaboration only.
    function automatic gear_rom_t build_gear_rom();
        gear_rom_t rom;
        logic [HASH_W-1:0] seed;
        logic [HASH_W-1:0] z;
        seed = MIX_GAMMA;
        for (int i = 0; i < GEAR_DEPTH; i++)
        begin
            seed   = seed + MIX_GAMMA;
            z      = seed;
            z      = (z ^ (z >> 30)) * MIX_MUL1;
            z      = (z ^ (z >> 27)) * MIX_MUL2;
            rom[i] = z ^ (z >> 31);
        end
        return rom;
    endfunction

    localparam gear_rom_t GEAR_ROM = build_gear_rom();

    // A mask of k bits sets bits 63, 60, 57 and so on downward.
    function automatic logic [HASH_W-1:0] spaced_mask(input logic [MASK_K_W-1:0] k);
        logic [HASH_W-1:0] m;
        m = '0;
        for (int i = 0; i < MASK_BITS_LIMIT; i++)
        begin
            if (MASK_K_W'(i) < k)
            begin
                m[HASH_W-1-3*i] = 1'b1;
            end
        end
        return m;
    endfunction

endpackage

[hdl/cdc_ifs.sv]
// Stream interfaces for the chunker: input bytes and per-byte cut results.
`timescale 1ns / 1ps
interface cdc_byte_if;
    logic                      valid;
    logic                      ready;
    logic [cdc_pkg::BYTE_W-1:0] byte_value;
    logic                      end_of_data;

    modport source (output valid, output byte_value, output end_of_data, input ready);
    modport sink   (input valid, input byte_value, input end_of_data, output ready);
endinterface

interface cdc_cut_if;
    logic                         valid;
    logic                         ready;
    logic                         cut;
    logic [cdc_pkg::OFFSET_W-1:0] chunk_offset;
    logic [cdc_pkg::LENGTH_W-1:0] chunk_length;
    logic [cdc_pkg::CAUSE_W-1:0]  cut_cause;

    modport source (output valid, output cut, output chunk_offset, output chunk_length,
                    output cut_cause, input ready);
    modport sink   (input valid, input cut, input chunk_offset, input chunk_length,
                    input cut_cause, output ready);
endinterface

[hdl/content_defined_chunker_top.sv]
// Content-defined chunker: gear rolling hash with strict and loose mask cut tests.
// Each accepted byte beat yields a result beat through the input register, then the
// result register; out_chan.ready low holds both. Hash and mask test are combinational.
// Throughput: one byte per cycle while out_chan.ready is high.
// Reset clears hash, chunk length and chunk start, empties both stages and
// loads the limit registers with 16384, 65536 and 262144.
`timescale 1ns / 1ps
module content_defined_chunker_top #(
    parameter int LENGTH_BITS   = cdc_pkg::LENGTH_BITS_DEF,
    parameter int OFFSET_BITS   = cdc_pkg::OFFSET_BITS_DEF,
    parameter int MAX_MASK_BITS = cdc_pkg::MAX_MASK_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    cdc_byte_if.sink                         in_chan,
    cdc_cut_if.source                        out_chan,
    input  logic                             cfg_we,
    input  logic [cdc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [cdc_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import cdc_pkg::*;

    localparam int CMP_W = (LENGTH_BITS > CFG_DATA_W) ? LENGTH_BITS : CFG_DATA_W;
    localparam logic [MASK_K_W-1:0] K_MAX = MASK_K_W'(MAX_MASK_BITS);

    // Limit registers
    logic [CFG_DATA_W-1:0] min_reg, tgt_reg, max_reg;

    // Input stage
    logic              s1_valid_reg;
    logic [BYTE_W-1:0] s1_byte_reg;
    logic              s1_eod_reg;

    // Chunk state
    logic [HASH_W-1:0]      hash_reg, hash_next;
    logic [LENGTH_BITS-1:0] bytes_reg, bytes_next;
    logic [OFFSET_BITS-1:0] start_reg, start_next;

    // Result stage
    logic                out_valid_reg;
    logic                out_cut_reg;
    logic [OFFSET_W-1:0] out_offset_reg, out_offset_next;
    logic [LENGTH_W-1:0] out_length_reg, out_length_next;
    cut_cause_t          out_cause_reg, cause_next;

    logic s1_advance;

    logic [CFG_DATA_W-1:0]  mn_eff, tg_eff, mx_eff;
    logic                   limits_ok;
    logic [MASK_K_W-1:0]    t_raw, t_clamp, k_strict, k_loose;
    logic [HASH_W-1:0]      strict_mask, loose_mask, hash_sum;
    logic [LENGTH_BITS-1:0] n;
    logic [CMP_W-1:0]       n_c, mn_c, tg_c, mx_c;
    logic                   in_strict, in_loose, len_full;

    assign s1_advance    = s1_valid_reg && (!out_valid_reg || out_chan.ready);
    assign in_chan.ready = !s1_valid_reg || s1_advance;

    // Limits and masks follow from the registers alone.
    always_comb
    begin
        limits_ok = (min_reg != '0) && (min_reg <= tgt_reg) && (tgt_reg <= max_reg);
        mn_eff    = limits_ok ? min_reg : RESET_MIN;
        tg_eff    = limits_ok ? tgt_reg : RESET_TARGET;
        mx_eff    = limits_ok ? max_reg : RESET_MAX;

        t_raw = '0;
        for (int i = 1; i < CFG_DATA_W; i++)
        begin
            if (tg_eff[i])
            begin
                t_raw = MASK_K_W'(i);
            end
        end
        // A target of one gives the same masks as a target of two.
        if (t_raw == '0)
        begin
            t_raw = MASK_K_W'(1);
        end
        t_clamp  = (t_raw > K_MAX) ? K_MAX : t_raw;
        k_strict = ((t_clamp + MASK_K_W'(2)) > K_MAX) ? K_MAX : (t_clamp + MASK_K_W'(2));
        k_loose  = (t_clamp <= MASK_K_W'(3)) ? MASK_K_W'(1) : (t_clamp - MASK_K_W'(2));
        if (k_loose > K_MAX)
        begin
            k_loose = K_MAX;
        end
        strict_mask = spaced_mask(k_strict);
        loose_mask  = spaced_mask(k_loose);
    end

    always_comb
    begin
        hash_sum = {hash_reg[HASH_W-2:0], 1'b0} + GEAR_ROM[s1_byte_reg];
        n        = bytes_reg + LENGTH_BITS'(1);
        n_c      = CMP_W'(n);
        mn_c     = CMP_W'(mn_eff);
        tg_c     = CMP_W'(tg_eff);
        mx_c     = CMP_W'(mx_eff);
        len_full = (n == '1);

        in_strict = (n_c > mn_c) && (n_c <= tg_c);
        in_loose  = !in_strict && (n_c > tg_c) && (n_c <= mx_c);

        priority if (in_strict && ((hash_sum & strict_mask) == '0))
            cause_next = CAUSE_STRICT;
        else if (in_loose && ((hash_sum & loose_mask) == '0))
            cause_next = CAUSE_LOOSE;
        else if ((n_c >= mx_c) || len_full)
            cause_next = CAUSE_MAX;
        else if (s1_eod_reg)
            cause_next = CAUSE_EOD;
        else
            cause_next = CAUSE_NONE;

        if (cause_next != CAUSE_NONE)
        begin
            hash_next       = '0;
            bytes_next      = '0;
            start_next      = s1_eod_reg ? '0 : (start_reg + OFFSET_BITS'(n));
            out_offset_next = OFFSET_W'(start_reg);
            out_length_next = LENGTH_W'(n);
        end
        else
        begin
            hash_next       = hash_sum;
            bytes_next      = n;
            start_next      = start_reg;
            out_offset_next = '0;
            out_length_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg <= RESET_MIN;
            tgt_reg <= RESET_TARGET;
            max_reg <= RESET_MAX;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MIN:    min_reg <= cfg_data;
                CFG_TARGET: tgt_reg <= cfg_data;
                CFG_MAX:    max_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            hash_reg      <= '0;
            bytes_reg     <= '0;
            start_reg     <= '0;
        end
        else
        begin
            if (in_chan.ready)
            begin
                s1_valid_reg <= in_chan.valid;
            end
            if (s1_advance)
            begin
                out_valid_reg <= 1'b1;
                hash_reg      <= hash_next;
                bytes_reg     <= bytes_next;
                start_reg     <= start_next;
            end
            else if (out_chan.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_chan.ready && in_chan.valid)
        begin
            s1_byte_reg <= in_chan.byte_value;
            s1_eod_reg  <= in_chan.end_of_data;
        end
        if (s1_advance)
        begin
            out_cut_reg    <= (cause_next != CAUSE_NONE);
            out_offset_reg <= out_offset_next;
            out_length_reg <= out_length_next;
            out_cause_reg  <= cause_next;
        end
    end

    assign out_chan.valid        = out_valid_reg;
    assign out_chan.cut          = out_cut_reg;
    assign out_chan.chunk_offset = out_offset_reg;
    assign out_chan.chunk_length = out_length_reg;
    assign out_chan.cut_cause    = out_cause_reg;

    // The length counter must never sit at its all-ones value between bytes.
    assert property (@(posedge clk) disable iff (!rst_n) bytes_reg != '1)
        else $error("chunk length counter reached its limit without a cut");

    // A cut always clears the rolling hash and the length counter.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_advance && (cause_next != CAUSE_NONE)) |=> (hash_reg == '0) && (bytes_reg == '0))
        else $error("chunk state not cleared after a cut");

    // A cut on the last byte of an object restarts offsets at zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_advance && (cause_next != CAUSE_NONE) && s1_eod_reg) |=> (start_reg == '0))
        else $error("chunk start not cleared at end of data");

    // Result beats without a cut carry zero length and no cause.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_cut_reg)
            |-> (out_length_reg == '0) && (out_cause_reg == CAUSE_NONE))
        else $error("non-cut result carries chunk data");

    // Every cut reports a nonempty chunk and a cause.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_cut_reg) |-> (out_length_reg != '0) && (out_cause_reg != CAUSE_NONE))
        else $error("cut result with empty chunk or no cause");

endmodule
